// File: rtl/blsd_pkg.sv
`default_nettype none

package blsd_pkg;

  // Configuration register map (index = paddr / 4)
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 3'd4;

  localparam logic [15:0] RST_BASELINE   = 16'd4096;
  localparam logic [15:0] RST_THRESHOLD  = 16'd2048;
  localparam logic [15:0] RST_COOLDOWN   = 16'd500;
  localparam logic [15:0] RST_LONG_PRESS = 16'd500;
  localparam logic [15:0] RST_REPEAT     = 16'd150;

  // Event codes
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_POWER   = 3'd1;
  localparam logic [2:0] EV_SHAKE   = 3'd2;
  localparam logic [2:0] EV_A_PRESS = 3'd3;
  localparam logic [2:0] EV_A_LONG  = 3'd4;
  localparam logic [2:0] EV_B_PRESS = 3'd5;
  localparam logic [2:0] EV_B_LONG  = 3'd6;

  // Sequencer step counts
  localparam int SQ_STEPS   = 4;   // three squares plus the final accumulate
  localparam int ROOT_STEPS = 16;  // one result bit per step
  localparam int CNT_W      = 4;
  localparam logic [31:0] ROOT_BIT0 = 32'h4000_0000;

  typedef struct packed {
    logic [15:0] baseline_magnitude;
    logic [15:0] shake_limit;
    logic [15:0] shake_quiet_ms;
    logic [15:0] hold_long_ms;
    logic [15:0] hold_rep_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               power_clicked;
    logic               a_pressed;
    logic               a_released;
    logic               b_pressed;
    logic               b_released;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } poll_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       sq_step;
    logic [1:0] sq_sel;
    logic       root_step;
    logic       check;
    logic       commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/blsd_poll_if.sv
`default_nettype none

interface blsd_poll_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_ms;
  logic               power_clicked;
  logic               a_pressed;
  logic               a_released;
  logic               b_pressed;
  logic               b_released;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (
    output valid, now_ms, power_clicked, a_pressed, a_released, b_pressed, b_released,
    output accel_x, accel_y, accel_z,
    input  ready
  );
  modport sink (
    input  valid, now_ms, power_clicked, a_pressed, a_released, b_pressed, b_released,
    input  accel_x, accel_y, accel_z,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/blsd_report_if.sv
`default_nettype none

interface blsd_report_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;

  modport source (output valid, event_code, input ready);
  modport sink   (input valid, event_code, output ready);
endinterface

`default_nettype wire

// File: rtl/button_longpress_shake_event_detector_top.sv
// A request accepted in the idle state passes the squarer steps, the 16-step iterative square
// root, a compare and a decide state; the event is registered on commit, and decide waits while
// the output register is full. A new request is accepted only after the previous one commits.
// The output register holds a result while the next request is accepted.
// Synchronous active-high reset restores register defaults and clears button/shake state.
`default_nettype none

module button_longpress_shake_event_detector_top #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [blsd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready,
  blsd_poll_if.sink                              poll,
  blsd_report_if.source                          report
);

  blsd_pkg::cfg_t  cfg;
  blsd_pkg::poll_t poll_fields;
  blsd_pkg::cmd_t  cmd;
  blsd_pkg::sts_t  sts;
  logic            in_ready;
  logic            out_valid;
  logic [2:0]      out_code;

  // Pack request payload
  always_comb begin
    poll_fields.now_ms        = poll.now_ms;
    poll_fields.power_clicked = poll.power_clicked;
    poll_fields.a_pressed     = poll.a_pressed;
    poll_fields.a_released    = poll.a_released;
    poll_fields.b_pressed     = poll.b_pressed;
    poll_fields.b_released    = poll.b_released;
    poll_fields.accel_x       = poll.accel_x;
    poll_fields.accel_y       = poll.accel_y;
    poll_fields.accel_z       = poll.accel_z;
  end

  assign poll.ready        = in_ready;
  assign report.valid      = out_valid;
  assign report.event_code = out_code;

  blsd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  blsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (poll.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  blsd_dp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .poll_in   (poll_fields),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (report.ready),
    .out_valid (out_valid),
    .out_code  (out_code)
  );

endmodule

`default_nettype wire

// File: rtl/blsd_cfg.sv
`default_nettype none

module blsd_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [blsd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready,
  output blsd_pkg::cfg_t                         cfg
);

  logic [blsd_pkg::CFG_IDX_W-1:0] idx;
  logic                           wr_en;

  assign idx    = paddr[blsd_pkg::CFG_ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.baseline_magnitude <= blsd_pkg::RST_BASELINE;
      cfg.shake_limit        <= blsd_pkg::RST_THRESHOLD;
      cfg.shake_quiet_ms     <= blsd_pkg::RST_COOLDOWN;
      cfg.hold_long_ms       <= blsd_pkg::RST_LONG_PRESS;
      cfg.hold_rep_ms        <= blsd_pkg::RST_REPEAT;
    end else if (wr_en) begin
      case (idx)
        blsd_pkg::REG_BASELINE:   cfg.baseline_magnitude <= pwdata[15:0];
        blsd_pkg::REG_THRESHOLD:  cfg.shake_limit        <= pwdata[15:0];
        blsd_pkg::REG_COOLDOWN:   cfg.shake_quiet_ms     <= pwdata[15:0];
        blsd_pkg::REG_LONG_PRESS: cfg.hold_long_ms       <= pwdata[15:0];
        blsd_pkg::REG_REPEAT:     cfg.hold_rep_ms        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      blsd_pkg::REG_BASELINE:   prdata = {16'd0, cfg.baseline_magnitude};
      blsd_pkg::REG_THRESHOLD:  prdata = {16'd0, cfg.shake_limit};
      blsd_pkg::REG_COOLDOWN:   prdata = {16'd0, cfg.shake_quiet_ms};
      blsd_pkg::REG_LONG_PRESS: prdata = {16'd0, cfg.hold_long_ms};
      blsd_pkg::REG_REPEAT:     prdata = {16'd0, cfg.hold_rep_ms};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/blsd_ctrl.sv
`default_nettype none

module blsd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output blsd_pkg::cmd_t      cmd,
  input  wire blsd_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ROOT,
    S_CHECK,
    S_DECIDE
  } state_t;

  state_t                       state;
  logic [blsd_pkg::CNT_W-1:0]   cnt;

  // Sequencer: squares, root iterations, compare, decide
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SQUARE;
            cnt   <= '0;
          end
        end
        S_SQUARE: begin
          if (cnt == blsd_pkg::CNT_W'(blsd_pkg::SQ_STEPS - 1)) begin
            state <= S_ROOT;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ROOT: begin
          if (cnt == blsd_pkg::CNT_W'(blsd_pkg::ROOT_STEPS - 1)) begin
            state <= S_CHECK;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_CHECK: state <= S_DECIDE;
        S_DECIDE: begin
          if (!sts.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Command decode
  always_comb begin
    in_ready      = (state == S_IDLE);
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.sq_step   = (state == S_SQUARE);
    cmd.sq_sel    = cnt[1:0];
    cmd.root_step = (state == S_ROOT);
    cmd.check     = (state == S_CHECK);
    cmd.commit    = (state == S_DECIDE) && !sts.out_busy;
  end

  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !in_ready)
    else $error("accepted a request while still busy");

  a_root_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT && cnt == blsd_pkg::CNT_W'(blsd_pkg::ROOT_STEPS - 1)) |=> cmd.check)
    else $error("root iteration count wrong");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !sts.out_busy)
    else $error("commit while output register full");

endmodule

`default_nettype wire

// File: rtl/blsd_dp.sv
`default_nettype none

module blsd_dp #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire blsd_pkg::cfg_t  cfg,
  input  wire blsd_pkg::poll_t poll_in,
  input  wire blsd_pkg::cmd_t  cmd,
  output blsd_pkg::sts_t       sts,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output logic [2:0]           out_code
);

  localparam logic [1:0] BTN_NONE  = 2'd0;
  localparam logic [1:0] BTN_PRESS = 2'd1;
  localparam logic [1:0] BTN_LONG  = 2'd2;

  typedef struct packed {
    logic       held;
    logic       fired;
    logic       set_start;
    logic       set_last;
    logic [1:0] kind;
  } btn_res_t;

  // Button press / long press / repeat decision
  function automatic btn_res_t btn_poll(input logic pressed, input logic released,
                                        input logic held, input logic fired,
                                        input logic long_due, input logic rep_due);
    btn_res_t r;
    r.held      = held && !released;
    r.fired     = fired && !released;
    r.set_start = 1'b0;
    r.set_last  = 1'b0;
    r.kind      = BTN_NONE;
    if (pressed) begin
      r.held      = 1'b1;
      r.fired     = 1'b0;
      r.set_start = 1'b1;
      r.set_last  = 1'b1;
      r.kind      = BTN_PRESS;
    end else if (r.held && !r.fired && long_due) begin
      r.fired    = 1'b1;
      r.set_last = 1'b1;
      r.kind     = BTN_LONG;
    end else if (r.held && r.fired && rep_due) begin
      r.set_last = 1'b1;
      r.kind     = BTN_LONG;
    end
    return r;
  endfunction

  // Latched request
  logic [TIME_WIDTH-1:0] now_t;
  logic                  power, a_p, a_r, b_p, b_r;
  logic signed [15:0]    ax, ay, az;
  logic [63:0]           now_wide;

  // Magnitude datapath
  logic [31:0]        prod;
  logic [31:0]        rem;
  logic [31:0]        res;
  logic [31:0]        bitv;
  logic signed [15:0] sq_op;
  logic signed [31:0] sq_prod;
  logic [32:0]        trial;
  logic [15:0]        mag;
  logic [15:0]        dev;

  // Compare flags
  logic dev_hit, shake_ok, a_long_due, a_rep_due, b_long_due, b_rep_due;

  // Persistent state
  logic [TIME_WIDTH-1:0] last_shake_time;
  logic                  a_held, a_long_fired, b_held, b_long_fired;
  logic [TIME_WIDTH-1:0] a_hold_start, a_last_repeat, b_hold_start, b_last_repeat;

  // Decision
  btn_res_t   a_res, b_res;
  logic [2:0] code_next;
  logic       upd_shake, upd_a, upd_b;

  assign now_wide = {32'd0, poll_in.now_ms};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_t <= now_wide[TIME_WIDTH-1:0];
      power <= poll_in.power_clicked;
      a_p   <= poll_in.a_pressed;
      a_r   <= poll_in.a_released;
      b_p   <= poll_in.b_pressed;
      b_r   <= poll_in.b_released;
      ax    <= poll_in.accel_x;
      ay    <= poll_in.accel_y;
      az    <= poll_in.accel_z;
    end
  end

  // Shared squarer operand
  always_comb begin
    case (cmd.sq_sel)
      2'd0:    sq_op = ax;
      2'd1:    sq_op = ay;
      default: sq_op = az;
    endcase
  end

  assign sq_prod = sq_op * sq_op;
  assign trial   = {1'b0, res} + {1'b0, bitv};
  assign mag     = res[15:0];
  assign dev     = (mag > cfg.baseline_magnitude) ? (mag - cfg.baseline_magnitude)
                                                  : (cfg.baseline_magnitude - mag);

  // Sum of squares, then bit-pair integer square root
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod <= '0;
      rem  <= '0;
      res  <= '0;
      bitv <= blsd_pkg::ROOT_BIT0;
    end else if (cmd.sq_step) begin
      prod <= sq_prod;
      rem  <= rem + prod;
    end else if (cmd.root_step) begin
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[31:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  // Threshold and elapsed-time compares
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      dev_hit    <= dev > cfg.shake_limit;
      shake_ok   <= (now_t - last_shake_time) > TIME_WIDTH'(cfg.shake_quiet_ms);
      a_long_due <= (now_t - a_hold_start)    > TIME_WIDTH'(cfg.hold_long_ms);
      a_rep_due  <= (now_t - a_last_repeat)   > TIME_WIDTH'(cfg.hold_rep_ms);
      b_long_due <= (now_t - b_hold_start)    > TIME_WIDTH'(cfg.hold_long_ms);
      b_rep_due  <= (now_t - b_last_repeat)   > TIME_WIDTH'(cfg.hold_rep_ms);
    end
  end

  // Priority: power, shake, button A, button B
  always_comb begin
    a_res     = btn_poll(a_p, a_r, a_held, a_long_fired, a_long_due, a_rep_due);
    b_res     = btn_poll(b_p, b_r, b_held, b_long_fired, b_long_due, b_rep_due);
    code_next = blsd_pkg::EV_NONE;
    upd_shake = 1'b0;
    upd_a     = 1'b0;
    upd_b     = 1'b0;
    if (power) begin
      code_next = blsd_pkg::EV_POWER;
    end else if (dev_hit && shake_ok) begin
      code_next = blsd_pkg::EV_SHAKE;
      upd_shake = 1'b1;
    end else begin
      upd_a = 1'b1;
      if (a_res.kind != BTN_NONE) begin
        code_next = (a_res.kind == BTN_PRESS) ? blsd_pkg::EV_A_PRESS : blsd_pkg::EV_A_LONG;
      end else begin
        upd_b = 1'b1;
        if (b_res.kind != BTN_NONE) begin
          code_next = (b_res.kind == BTN_PRESS) ? blsd_pkg::EV_B_PRESS
                                                : blsd_pkg::EV_B_LONG;
        end
      end
    end
  end

  // State update on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      last_shake_time <= '0;
      a_held          <= 1'b0;
      a_long_fired    <= 1'b0;
      a_hold_start    <= '0;
      a_last_repeat   <= '0;
      b_held          <= 1'b0;
      b_long_fired    <= 1'b0;
      b_hold_start    <= '0;
      b_last_repeat   <= '0;
    end else if (cmd.commit) begin
      if (upd_shake) last_shake_time <= now_t;
      if (upd_a) begin
        a_held       <= a_res.held;
        a_long_fired <= a_res.fired;
        if (a_res.set_start) a_hold_start  <= now_t;
        if (a_res.set_last)  a_last_repeat <= now_t;
      end
      if (upd_b) begin
        b_held       <= b_res.held;
        b_long_fired <= b_res.fired;
        if (b_res.set_start) b_hold_start  <= now_t;
        if (b_res.set_last)  b_last_repeat <= now_t;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_code <= code_next;
  end

  assign sts.out_busy = out_valid && !out_ready;

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result not presented after commit");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_code <= blsd_pkg::EV_B_LONG)
    else $error("event code out of range");

  a_root_done: assert property (@(posedge clk) disable iff (rst)
    cmd.check |-> (bitv == '0 && res[31:16] == '0))
    else $error("square root not finished at compare");

endmodule

`default_nettype wire
